[rtl/core/pup_pkg.sv]
// ----------------------------------------------------------------------------
// pup_pkg
// Shared constants, types and helpers of the quality-guided phase unwrapper.
// ----------------------------------------------------------------------------
package pup_pkg;

	// Grid limits and fixed field widths.
	localparam int unsigned MAX_ROWS  = 256;
	localparam int unsigned MAX_COLS  = 256;
	localparam int unsigned PIX_W     = 16;
	localparam int unsigned EXT_W     = PIX_W + 1;
	localparam int unsigned DIM_W     = 9;
	localparam int unsigned PH_W      = 16;
	localparam int unsigned Q_W       = 16;
	localparam int unsigned UNW_W     = 40;
	localparam int unsigned X_W       = $clog2(MAX_ROWS);
	localparam int unsigned Y_W       = $clog2(MAX_COLS);
	localparam int unsigned STORE_PIX = 1 << PIX_W;

	// Configuration register indexes.
	localparam logic CFG_ROWS = 1'b0;
	localparam logic CFG_COLS = 1'b1;

	// Operation codes.
	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_READ = 1'b1;

	// Result kinds.
	localparam logic KIND_DATA   = 1'b0;
	localparam logic KIND_NOTICE = 1'b1;

	// Active grid configuration.
	typedef struct packed {
		logic [DIM_W-1:0] rows;
		logic [DIM_W-1:0] cols;
		logic [EXT_W-1:0] n;
	} cfg_t;

	// One stored pixel.
	typedef struct packed {
		logic            missing;
		logic [PH_W-1:0] phase;
		logic [Q_W-1:0]  q;
	} pixel_t;

	// One heap entry: its key, its address and its grid coordinates.
	typedef struct packed {
		logic [Q_W-1:0]   q;
		logic [PIX_W-1:0] pix;
		logic [Y_W-1:0]   y;
		logic [X_W-1:0]   x;
	} hent_t;

	localparam int unsigned PIXEL_W = $bits(pixel_t);
	localparam int unsigned HENT_W  = $bits(hent_t);

	// Clamp a written dimension to the range one up to the limit.
	function automatic logic [DIM_W-1:0] clamp_dim(logic [DIM_W-1:0] v, int unsigned maxv);
		logic [DIM_W-1:0] r;
		r = (v == '0) ? DIM_W'(1) : v;
		if (32'(r) > maxv) begin
			r = DIM_W'(maxv);
		end
		return r;
	endfunction

	// Pixel count of a grid, capped at the store depth.
	function automatic logic [EXT_W-1:0] grid_count(logic [DIM_W-1:0] r, logic [DIM_W-1:0] c);
		logic [2*DIM_W-1:0] p;
		p = r * c;
		if (32'(p) > STORE_PIX) begin
			return EXT_W'(STORE_PIX);
		end
		return EXT_W'(p);
	endfunction

	localparam logic [DIM_W-1:0] RST_ROWS = clamp_dim(DIM_W'(256), MAX_ROWS);
	localparam logic [DIM_W-1:0] RST_COLS = clamp_dim(DIM_W'(256), MAX_COLS);

endpackage

[rtl/core/pup_ram.sv]
// ----------------------------------------------------------------------------
// pup_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module pup_ram #(
	parameter int unsigned ADDR_W = 16,
	parameter int unsigned DATA_W = 16
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [1 << ADDR_W];

	// Write and registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[rtl/core/pup_seq.sv]
// ----------------------------------------------------------------------------
// pup_seq
// Sequencer of the unwrapper: loads, reads, clearing, start search, heap
// push and pop through one heap RAM port, and the neighbour walk.
// ----------------------------------------------------------------------------
module pup_seq
	import pup_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  cfg_t              cfg,
	input  logic              start,
	output logic              busy,
	input  logic              operation,
	input  logic [PIX_W-1:0]  pixel_index,
	input  logic [PH_W-1:0]   phase_sample,
	input  logic [Q_W-1:0]    quality,
	input  logic              sample_missing,
	input  logic              last_pixel,
	output logic              done,
	output logic [UNW_W-1:0]  unwrapped_phase,
	output logic              reached,
	output logic              result_kind,
	// Pixel store.
	output logic              pix_we,
	output logic [PIX_W-1:0]  pix_waddr,
	output pixel_t            pix_wdata,
	output logic [PIX_W-1:0]  pix_raddr,
	input  pixel_t            pix_rdata,
	// Reached marks.
	output logic              rch_we,
	output logic [PIX_W-1:0]  rch_waddr,
	output logic              rch_wdata,
	output logic [PIX_W-1:0]  rch_raddr,
	input  logic              rch_rdata,
	// Unwrapped values.
	output logic              unw_we,
	output logic [PIX_W-1:0]  unw_waddr,
	output logic [UNW_W-1:0]  unw_wdata,
	output logic [PIX_W-1:0]  unw_raddr,
	input  logic [UNW_W-1:0]  unw_rdata,
	// Heap.
	output logic              hp_we,
	output logic [PIX_W-1:0]  hp_waddr,
	output hent_t             hp_wdata,
	output logic [PIX_W-1:0]  hp_raddr,
	input  hent_t             hp_rdata
);

	localparam logic [4:0] ST_IDLE     = 5'd0;
	localparam logic [4:0] ST_RD       = 5'd1;
	localparam logic [4:0] ST_CLR      = 5'd2;
	localparam logic [4:0] ST_SCAN_RD  = 5'd3;
	localparam logic [4:0] ST_SCAN_EV  = 5'd4;
	localparam logic [4:0] ST_SEED     = 5'd5;
	localparam logic [4:0] ST_PUSH_CHK = 5'd6;
	localparam logic [4:0] ST_PUSH_EV  = 5'd7;
	localparam logic [4:0] ST_NB       = 5'd8;
	localparam logic [4:0] ST_NB_EV    = 5'd9;
	localparam logic [4:0] ST_POP      = 5'd10;
	localparam logic [4:0] ST_POP_T    = 5'd11;
	localparam logic [4:0] ST_POP_L    = 5'd12;
	localparam logic [4:0] ST_SIFT     = 5'd13;
	localparam logic [4:0] ST_SIFT_A   = 5'd14;
	localparam logic [4:0] ST_SIFT_B   = 5'd15;
	localparam logic [4:0] ST_SIFT_C   = 5'd16;
	localparam logic [4:0] ST_HPIX     = 5'd17;
	localparam logic [4:0] ST_HPIX_W   = 5'd18;
	localparam logic [4:0] ST_DONE     = 5'd19;

	localparam logic [2:0] NB_END = 3'd4;

	// Control registers.
	logic [4:0]       state_q;
	logic [PIX_W-1:0] k_q;
	logic [X_W-1:0]   kx_q;
	logic [Y_W-1:0]   ky_q;
	logic             found_q;
	logic [EXT_W-1:0] nunw_q;
	logic [EXT_W-1:0] cnt_q;
	logic [PIX_W-1:0] c_q;
	logic [PIX_W-1:0] r_q;
	logic [PIX_W-1:0] cidx_q;
	logic [2:0]       nb_q;
	logic             done_q;

	// Payload registers.
	hent_t            best_q;
	logic [PH_W-1:0]  best_ph_q;
	logic [PIX_W-1:0] rd_idx_q;
	hent_t            e_q;
	hent_t            top_q;
	hent_t            last_q;
	hent_t            ch_q;
	hent_t            t_q;
	logic [PH_W-1:0]  ph_h_q;
	logic [UNW_W-1:0] unw_h_q;
	logic [UNW_W-1:0] out_unw_q;
	logic             out_rch_q;
	logic             out_kind_q;

	// Derived values.
	logic             accept;
	logic [EXT_W-1:0] k_last;
	logic             better;
	logic [PIX_W-1:0] parent;
	logic [EXT_W-1:0] lchild;
	logic [EXT_W-1:0] rchild;
	logic             nb_ok;
	hent_t            nb_t;
	logic [EXT_W-1:0] h_ext;
	logic [PH_W-1:0]  dphase;
	logic [UNW_W-1:0] unw_next;
	logic             rd_ok;

	assign accept  = start && (state_q == ST_IDLE);
	assign busy    = (state_q != ST_IDLE);
	assign k_last  = cfg.n - EXT_W'(1);
	assign better  = !pix_rdata.missing && (!found_q || (pix_rdata.q > best_q.q));
	assign parent  = (c_q - PIX_W'(1)) >> 1;
	assign lchild  = {r_q, 1'b1};
	assign rchild  = EXT_W'(cidx_q) + EXT_W'(1);
	assign h_ext   = EXT_W'(top_q.pix);
	assign dphase  = pix_rdata.phase - ph_h_q;
	assign unw_next = unw_h_q + {{(UNW_W-PH_W){dphase[PH_W-1]}}, dphase};
	assign rd_ok   = rch_rdata && (EXT_W'(rd_idx_q) < cfg.n) && (EXT_W'(rd_idx_q) < nunw_q);

	// Neighbour of the popped pixel: up, down, left, right.
	always_comb begin
		nb_t  = top_q;
		nb_ok = 1'b0;
		unique case (nb_q)
			3'd0: begin
				nb_ok     = (top_q.x != '0);
				nb_t.pix  = top_q.pix - PIX_W'(1);
				nb_t.x    = top_q.x - X_W'(1);
			end
			3'd1: begin
				nb_ok     = ((EXT_W'(top_q.x) + EXT_W'(1)) < EXT_W'(cfg.rows))
				            && ((h_ext + EXT_W'(1)) < cfg.n);
				nb_t.pix  = top_q.pix + PIX_W'(1);
				nb_t.x    = top_q.x + X_W'(1);
			end
			3'd2: begin
				nb_ok     = (top_q.y != '0);
				nb_t.pix  = top_q.pix - PIX_W'(cfg.rows);
				nb_t.y    = top_q.y - Y_W'(1);
			end
			3'd3: begin
				nb_ok     = ((EXT_W'(top_q.y) + EXT_W'(1)) < EXT_W'(cfg.cols))
				            && ((h_ext + EXT_W'(cfg.rows)) < cfg.n);
				nb_t.pix  = top_q.pix + PIX_W'(cfg.rows);
				nb_t.y    = top_q.y + Y_W'(1);
			end
			default: begin
				nb_ok = 1'b0;
			end
		endcase
	end

	// Memory port steering.
	always_comb begin
		pix_we    = accept && (operation == OP_LOAD);
		pix_waddr = pixel_index;
		pix_wdata = '{missing: sample_missing, phase: phase_sample, q: quality};
		pix_raddr = k_q;
		rch_we    = 1'b0;
		rch_waddr = t_q.pix;
		rch_wdata = 1'b1;
		rch_raddr = pixel_index;
		unw_we    = 1'b0;
		unw_waddr = t_q.pix;
		unw_wdata = unw_next;
		unw_raddr = pixel_index;
		hp_we     = 1'b0;
		hp_waddr  = c_q;
		hp_wdata  = e_q;
		hp_raddr  = parent;
		unique case (state_q)
			ST_CLR: begin
				rch_we    = 1'b1;
				rch_waddr = k_q;
				rch_wdata = 1'b0;
			end
			ST_SEED: begin
				rch_we    = 1'b1;
				rch_waddr = best_q.pix;
				unw_we    = 1'b1;
				unw_waddr = best_q.pix;
				unw_wdata = {{(UNW_W-PH_W){best_ph_q[PH_W-1]}}, best_ph_q};
			end
			ST_PUSH_CHK: begin
				hp_we = (c_q == '0);
			end
			ST_PUSH_EV: begin
				hp_we = 1'b1;
				if (hp_rdata.q < e_q.q) begin
					hp_wdata = hp_rdata;
				end
			end
			ST_NB: begin
				pix_raddr = nb_t.pix;
				rch_raddr = nb_t.pix;
			end
			ST_NB_EV: begin
				rch_we = !rch_rdata && !pix_rdata.missing;
				unw_we = !rch_rdata && !pix_rdata.missing;
			end
			ST_POP: begin
				hp_raddr = '0;
			end
			ST_POP_T: begin
				hp_raddr = PIX_W'(cnt_q - EXT_W'(1));
			end
			ST_SIFT: begin
				hp_raddr = lchild[PIX_W-1:0];
				hp_waddr = r_q;
				hp_wdata = last_q;
				hp_we    = !(lchild < cnt_q);
			end
			ST_SIFT_A: begin
				hp_raddr = rchild[PIX_W-1:0];
			end
			ST_SIFT_C: begin
				hp_we    = 1'b1;
				hp_waddr = r_q;
				hp_wdata = (last_q.q < ch_q.q) ? ch_q : last_q;
			end
			ST_HPIX: begin
				pix_raddr = top_q.pix;
				unw_raddr = top_q.pix;
			end
			default: begin
			end
		endcase
	end

	// State machine and control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			k_q     <= '0;
			kx_q    <= '0;
			ky_q    <= '0;
			found_q <= 1'b0;
			nunw_q  <= '0;
			cnt_q   <= '0;
			c_q     <= '0;
			r_q     <= '0;
			cidx_q  <= '0;
			nb_q    <= NB_END;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (operation == OP_READ) begin
							state_q <= ST_RD;
						end else if (last_pixel) begin
							state_q <= ST_CLR;
							k_q     <= '0;
							nunw_q  <= cfg.n;
						end
					end
				end
				ST_RD: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				ST_CLR: begin
					if (EXT_W'(k_q) == k_last) begin
						k_q     <= '0;
						kx_q    <= '0;
						ky_q    <= '0;
						found_q <= 1'b0;
						state_q <= ST_SCAN_RD;
					end else begin
						k_q <= k_q + PIX_W'(1);
					end
				end
				ST_SCAN_RD: begin
					state_q <= ST_SCAN_EV;
				end
				ST_SCAN_EV: begin
					if (better) begin
						found_q <= 1'b1;
					end
					if (EXT_W'(k_q) == k_last) begin
						state_q <= (found_q || better) ? ST_SEED : ST_DONE;
					end else begin
						k_q <= k_q + PIX_W'(1);
						if ((EXT_W'(kx_q) + EXT_W'(1)) == EXT_W'(cfg.rows)) begin
							kx_q <= '0;
							ky_q <= ky_q + Y_W'(1);
						end else begin
							kx_q <= kx_q + X_W'(1);
						end
						state_q <= ST_SCAN_RD;
					end
				end
				ST_SEED: begin
					c_q     <= '0;
					cnt_q   <= EXT_W'(1);
					nb_q    <= NB_END;
					state_q <= ST_PUSH_CHK;
				end
				ST_PUSH_CHK: begin
					state_q <= (c_q == '0) ? ST_NB : ST_PUSH_EV;
				end
				ST_PUSH_EV: begin
					if (hp_rdata.q < e_q.q) begin
						c_q     <= parent;
						state_q <= ST_PUSH_CHK;
					end else begin
						state_q <= ST_NB;
					end
				end
				ST_NB: begin
					if (nb_q == NB_END) begin
						state_q <= ST_POP;
					end else if (nb_ok) begin
						state_q <= ST_NB_EV;
					end else begin
						nb_q <= nb_q + 3'd1;
					end
				end
				ST_NB_EV: begin
					nb_q <= nb_q + 3'd1;
					if (!rch_rdata && !pix_rdata.missing) begin
						c_q     <= cnt_q[PIX_W-1:0];
						cnt_q   <= cnt_q + EXT_W'(1);
						state_q <= ST_PUSH_CHK;
					end else begin
						state_q <= ST_NB;
					end
				end
				ST_POP: begin
					state_q <= (cnt_q == '0) ? ST_DONE : ST_POP_T;
				end
				ST_POP_T: begin
					cnt_q   <= cnt_q - EXT_W'(1);
					state_q <= ST_POP_L;
				end
				ST_POP_L: begin
					r_q     <= '0;
					state_q <= (cnt_q == '0) ? ST_HPIX : ST_SIFT;
				end
				ST_SIFT: begin
					cidx_q  <= lchild[PIX_W-1:0];
					state_q <= (lchild < cnt_q) ? ST_SIFT_A : ST_HPIX;
				end
				ST_SIFT_A: begin
					state_q <= (rchild < cnt_q) ? ST_SIFT_B : ST_SIFT_C;
				end
				ST_SIFT_B: begin
					if (ch_q.q < hp_rdata.q) begin
						cidx_q <= rchild[PIX_W-1:0];
					end
					state_q <= ST_SIFT_C;
				end
				ST_SIFT_C: begin
					if (last_q.q < ch_q.q) begin
						r_q     <= cidx_q;
						state_q <= ST_SIFT;
					end else begin
						state_q <= ST_HPIX;
					end
				end
				ST_HPIX: begin
					state_q <= ST_HPIX_W;
				end
				ST_HPIX_W: begin
					nb_q    <= '0;
					state_q <= ST_NB;
				end
				ST_DONE: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			rd_idx_q <= pixel_index;
		end
		if ((state_q == ST_SCAN_EV) && better) begin
			best_q    <= '{q: pix_rdata.q, pix: k_q, y: ky_q, x: kx_q};
			best_ph_q <= pix_rdata.phase;
		end
		if (state_q == ST_SEED) begin
			e_q <= best_q;
		end
		if (state_q == ST_NB) begin
			t_q <= nb_t;
		end
		if ((state_q == ST_NB_EV) && !rch_rdata && !pix_rdata.missing) begin
			e_q <= '{q: pix_rdata.q, pix: t_q.pix, y: t_q.y, x: t_q.x};
		end
		if (state_q == ST_POP_T) begin
			top_q <= hp_rdata;
		end
		if (state_q == ST_POP_L) begin
			last_q <= hp_rdata;
		end
		if (state_q == ST_SIFT_A) begin
			ch_q <= hp_rdata;
		end
		if ((state_q == ST_SIFT_B) && (ch_q.q < hp_rdata.q)) begin
			ch_q <= hp_rdata;
		end
		if (state_q == ST_HPIX_W) begin
			ph_h_q  <= pix_rdata.phase;
			unw_h_q <= unw_rdata;
		end
		if (state_q == ST_RD) begin
			out_unw_q  <= rd_ok ? unw_rdata : '0;
			out_rch_q  <= rd_ok;
			out_kind_q <= KIND_DATA;
		end
		if (state_q == ST_DONE) begin
			out_unw_q  <= '0;
			out_rch_q  <= found_q;
			out_kind_q <= KIND_NOTICE;
		end
	end

	assign done            = done_q;
	assign unwrapped_phase = out_unw_q;
	assign reached         = out_rch_q;
	assign result_kind     = out_kind_q;

endmodule

[rtl/core/quality_guided_phase_unwrap_core.sv]
// ----------------------------------------------------------------------------
// quality_guided_phase_unwrap_core
// Quality-guided phase unwrapper over a column-major pixel grid.
// ----------------------------------------------------------------------------
// Usage:
//   An item is taken at a clock edge with start high and busy low. A load
//   (operation 0) writes one pixel; the next item may follow at once. A
//   load with last_pixel runs the unwrap and ends with one notice beat; a
//   read (operation 1) gives one data beat after the sequencer's read state.
//   Each result beat is on the outputs for exactly one cycle with done high;
//   the receiver cannot stall, so results are never held back.
//   An unwrap of n pixels clears the reached marks, scans all n pixels for
//   the start pixel, then per pixel pops the heap, checks four neighbours
//   and pushes each one not yet reached and not missing. Every step goes
//   through the one read port and one write port of each RAM, the heap RAM
//   setting the pace. Grid size is written through cfg_we, cfg_index and
//   cfg_data; write it only while idle, as the block does not enforce this.
//   Reset returns the grid to its full size and marks no result as valid;
//   stored pixels keep whatever the RAMs hold.
// ----------------------------------------------------------------------------
module quality_guided_phase_unwrap_core
	import pup_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [DIM_W-1:0]  cfg_data,
	input  logic              start,
	output logic              busy,
	input  logic              operation,
	input  logic [PIX_W-1:0]  pixel_index,
	input  logic [PH_W-1:0]   phase_sample,
	input  logic [Q_W-1:0]    quality,
	input  logic              sample_missing,
	input  logic              last_pixel,
	output logic              done,
	output logic [UNW_W-1:0]  unwrapped_phase,
	output logic              reached,
	output logic              result_kind
);

	logic [DIM_W-1:0] rows_q;
	logic [DIM_W-1:0] cols_q;
	logic [EXT_W-1:0] n_q;
	cfg_t             cfg;

	logic              pix_we;
	logic [PIX_W-1:0]  pix_waddr;
	pixel_t            pix_wdata;
	logic [PIX_W-1:0]  pix_raddr;
	pixel_t            pix_rdata;
	logic              rch_we;
	logic [PIX_W-1:0]  rch_waddr;
	logic              rch_wdata;
	logic [PIX_W-1:0]  rch_raddr;
	logic              rch_rdata;
	logic              unw_we;
	logic [PIX_W-1:0]  unw_waddr;
	logic [UNW_W-1:0]  unw_wdata;
	logic [PIX_W-1:0]  unw_raddr;
	logic [UNW_W-1:0]  unw_rdata;
	logic              hp_we;
	logic [PIX_W-1:0]  hp_waddr;
	hent_t             hp_wdata;
	logic [PIX_W-1:0]  hp_raddr;
	hent_t             hp_rdata;

	// Grid size registers, clamped on write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= RST_ROWS;
			cols_q <= RST_COLS;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_ROWS: rows_q <= clamp_dim(cfg_data, MAX_ROWS);
					CFG_COLS: cols_q <= clamp_dim(cfg_data, MAX_COLS);
					default: begin
					end
				endcase
			end
		end
	end

	// Pixel count follows the size registers with no delay.
	assign n_q = grid_count(rows_q, cols_q);

	assign cfg = '{rows: rows_q, cols: cols_q, n: n_q};

	// Sequencer.
	pup_seq u_seq (
		.clk, .arst_n, .cfg, .start, .busy, .operation, .pixel_index,
		.phase_sample, .quality, .sample_missing, .last_pixel, .done,
		.unwrapped_phase, .reached, .result_kind,
		.pix_we, .pix_waddr, .pix_wdata, .pix_raddr, .pix_rdata,
		.rch_we, .rch_waddr, .rch_wdata, .rch_raddr, .rch_rdata,
		.unw_we, .unw_waddr, .unw_wdata, .unw_raddr, .unw_rdata,
		.hp_we, .hp_waddr, .hp_wdata, .hp_raddr, .hp_rdata
	);

	// Pixel store: phase, quality and missing mark.
	pup_ram #(.ADDR_W(PIX_W), .DATA_W(PIXEL_W)) u_pix_ram (
		.clk, .we(pix_we), .waddr(pix_waddr), .wdata(pix_wdata),
		.raddr(pix_raddr), .rdata(pix_rdata)
	);

	// Reached marks.
	pup_ram #(.ADDR_W(PIX_W), .DATA_W(1)) u_rch_ram (
		.clk, .we(rch_we), .waddr(rch_waddr), .wdata(rch_wdata),
		.raddr(rch_raddr), .rdata(rch_rdata)
	);

	// Unwrapped values.
	pup_ram #(.ADDR_W(PIX_W), .DATA_W(UNW_W)) u_unw_ram (
		.clk, .we(unw_we), .waddr(unw_waddr), .wdata(unw_wdata),
		.raddr(unw_raddr), .rdata(unw_rdata)
	);

	// Max-heap of pixels keyed on quality.
	pup_ram #(.ADDR_W(PIX_W), .DATA_W(HENT_W)) u_heap_ram (
		.clk, .we(hp_we), .waddr(hp_waddr), .wdata(hp_wdata),
		.raddr(hp_raddr), .rdata(hp_rdata)
	);

endmodule

[rtl/core/pup_checker.sv]
// ----------------------------------------------------------------------------
// pup_checker
// Port-level assertions of the unwrapper, bound to the top level.
// ----------------------------------------------------------------------------
module pup_checker
	import pup_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic              operation,
	input logic              last_pixel,
	input logic              done,
	input logic [UNW_W-1:0]  unwrapped_phase,
	input logic              reached,
	input logic              result_kind
);

	// A read beat returns its data beat.
	a_read_result: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (operation == OP_READ)) |=> ##1 (done && (result_kind == KIND_DATA)))
		else $error("read beat without its data beat");

	// A plain load leaves the block ready in the next cycle.
	a_load_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (operation == OP_LOAD) && !last_pixel) |=> !busy)
		else $error("plain load left the block busy");

	// An unreached pixel reads zero.
	a_unreached_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (result_kind == KIND_DATA) && !reached) |-> (unwrapped_phase == '0))
		else $error("unreached pixel read nonzero");

	// The finished notice carries zero phase.
	a_notice_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (result_kind == KIND_NOTICE)) |-> (unwrapped_phase == '0))
		else $error("notice with nonzero phase");

endmodule

bind quality_guided_phase_unwrap_core pup_checker u_chk (.*);
